// ===== rtl/sfv_pkg.sv =====
// Shared constants, types and the exponential table for the softmax vector unit.
`default_nettype none
package sfv_pkg;
   localparam int MaxChannels = 64;
   localparam int ExpTableDepth = 256;
   localparam int IdxWidth = $clog2(MaxChannels);
   localparam int CountWidth = IdxWidth + 1;
   localparam int TabWidth = $clog2(ExpTableDepth);
   localparam logic [16:0] Log2eQ16 = 17'd94548;
   localparam longint Ln2Q30 = 64'd744261118;
   localparam int SumWidth = 23;
   localparam int RecipWidth = 33;

   typedef logic [15:0] word_type;

   // Shift-and-subtract quotient of a wide value by a small term index.
   function automatic logic [63:0] quotient_small(input logic [63:0] num,
                                                  input logic [3:0] den);
      logic [63:0] q;
      logic [63:0] r;
      q = '0;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         r = {r[62:0], num[b]};
         if (r >= 64'(den)) begin
            r = r - 64'(den);
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic logic [15:0] exp_table_entry(input logic [TabWidth-1:0] k);
      logic [63:0] y;
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] val;
      y = (64'(k) * Ln2Q30) >> TabWidth;
      term = 64'd1 << 30;
      sum = 64'd1 << 30;
      for (int i = 1; i <= 12; i++) begin
         term = quotient_small((term * y) >> 30, 4'(i));
         if ((i & 1) == 1) sum = sum - term;
         else sum = sum + term;
      end
      val = (sum + (64'd1 << 13)) >> 14;
      exp_table_entry = (val > 64'd65535) ? 16'hFFFF : val[15:0];
   endfunction

   typedef logic [15:0] exp_rom_type [ExpTableDepth];

   function automatic exp_rom_type build_exp_rom();
      exp_rom_type r;
      for (int k = 0; k < ExpTableDepth; k++) r[k] = exp_table_entry(TabWidth'(k));
      return r;
   endfunction

   localparam exp_rom_type ExpRom = build_exp_rom();
endpackage
`default_nettype wire

// ===== rtl/sfv_divider.sv =====
// Restoring divider forming floor(2^32 / sum), one quotient bit per cycle.
`default_nettype none
module sfv_divider
   import sfv_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic [SumWidth-1:0]     divisor,
   output logic                         done,
   output logic [RecipWidth-1:0]        quotient
);
   logic [5:0] bit_ff, bit_in;
   logic busy_ff, busy_in;
   logic [SumWidth:0] rem_ff, rem_in;
   logic [RecipWidth-1:0] quo_ff, quo_in;
   logic [SumWidth-1:0] div_ff, div_in;
   logic [SumWidth:0] trial;
   logic dividend_bit;

   always_comb begin
      busy_in = busy_ff;
      bit_in = bit_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      div_in = div_ff;
      done = 1'b0;
      dividend_bit = (bit_ff == 6'd32);
      trial = {rem_ff[SumWidth-1:0], dividend_bit};
      if (start) begin
         busy_in = 1'b1;
         bit_in = 6'd32;
         rem_in = '0;
         quo_in = '0;
         div_in = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = trial - {1'b0, div_ff};
            quo_in = {quo_ff[RecipWidth-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[RecipWidth-2:0], 1'b0};
         end
         if (bit_ff == 6'd0) begin
            busy_in = 1'b0;
            done = 1'b1;
         end else begin
            bit_in = bit_ff - 6'd1;
         end
      end
   end

   assign quotient = quo_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         bit_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         bit_ff <= bit_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end
endmodule
`default_nettype wire

// ===== rtl/softmax_forward_vector_unit.sv =====
// Top level of the max-subtracted softmax vector unit.
`default_nettype none
// Scores stream in one transaction per cycle while the vector fills; each is buffered
// and the running maximum tracked. Once the vector ends (last flag or the configured
// length), the unit stops taking input and runs three passes:
// an exponential pass over each element (memory read, log2(e) multiply, table
// lookup and shift), a reciprocal of the sum from a bit-serial divider, and a
// normalize pass over each element (memory read, multiply, rounding into the
// output register), stretched while a result waits on rsp_tready. The input
// stays held until the last result of the vector is registered. Results leave
// through a registered output stage in input order.
module softmax_forward_vector_unit
   import sfv_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // score [15:0]
   input  wire logic        req_tlast,   // last_in
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // probability [15:0]
   output logic             rsp_tlast,   // last_out
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [7:0]  csr_data    // channel_count [6:0], bit 7 zero
);
   localparam logic [2:0] StLoad = 3'd0;
   localparam logic [2:0] StExpRd = 3'd1;
   localparam logic [2:0] StExpMul = 3'd2;
   localparam logic [2:0] StExpWr = 3'd3;
   localparam logic [2:0] StDiv = 3'd4;
   localparam logic [2:0] StNrmRd = 3'd5;
   localparam logic [2:0] StNrmMul = 3'd6;
   localparam logic [2:0] StOut = 3'd7;

   logic [2:0] state_ff, state_in;
   logic [6:0] chan_ff;
   logic signed [15:0] max_ff, max_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic [IdxWidth-1:0] ptr_ff, ptr_in;
   logic [SumWidth-1:0] sum_ff, sum_in;
   logic [RecipWidth-1:0] recip_ff;
   logic [15:0] score_mem [MaxChannels];
   logic [15:0] exp_mem [MaxChannels];
   logic [15:0] score_rd_ff, exp_rd_ff;
   logic [33:0] prod_ff;
   logic [48:0] nprod_ff;
   logic [15:0] rsp_data_ff;
   logic rsp_valid_ff, rsp_last_ff;
   logic [CountWidth-1:0] limit;
   logic accept, vec_end, div_start, div_done;
   logic [RecipWidth-1:0] div_q;
   logic [16:0] diff;
   logic [15:0] ip;
   logic [15:0] e_val;
   logic [49:0] rounded;
   logic last_ptr;

   assign req_tready = (state_ff == StLoad);
   assign accept = req_tvalid && req_tready;
   assign csr_ready = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tlast = rsp_last_ff;

   always_comb begin
      if (chan_ff == 7'd0) limit = CountWidth'(1);
      else if (chan_ff > 7'(MaxChannels)) limit = CountWidth'(MaxChannels);
      else limit = CountWidth'(chan_ff);
   end

   // The index clamps to the top entry once the memory is full.
   logic [IdxWidth-1:0] wr_idx;
   assign wr_idx = (count_ff >= CountWidth'(MaxChannels)) ? IdxWidth'(MaxChannels - 1)
                                                          : count_ff[IdxWidth-1:0];
   logic [CountWidth-1:0] count_inc;
   assign count_inc = CountWidth'(wr_idx) + CountWidth'(1);
   assign vec_end = req_tlast || (count_inc >= limit);

   // prod_ff holds distance times log2(e) in Q.24: the integer part of the
   // exponent sits in bits 33:24, the table index in the eight bits below it.
   assign diff = {max_ff[15], max_ff} - {score_rd_ff[15], score_rd_ff};
   assign ip = 16'(prod_ff[33:24]);
   assign e_val = (ip >= 16'd17) ? 16'd0 : (ExpRom[prod_ff[23:16]] >> ip[4:0]);
   assign rounded = {1'b0, nprod_ff} + 50'd32768;
   assign last_ptr = (CountWidth'(ptr_ff) + CountWidth'(1) == count_ff);
   assign div_start = (state_ff == StExpWr) && last_ptr;

   sfv_divider u_div (
      .clock(clock), .reset(reset), .start(div_start), .divisor(sum_in),
      .done(div_done), .quotient(div_q)
   );

   always_comb begin
      state_in = state_ff;
      max_in = max_ff;
      count_in = count_ff;
      ptr_in = ptr_ff;
      sum_in = sum_ff;
      unique case (state_ff)
         StLoad: begin
            if (accept) begin
               if ($signed(req_tdata) > max_ff) max_in = $signed(req_tdata);
               count_in = count_inc;
               if (vec_end) begin
                  state_in = StExpRd;
                  ptr_in = '0;
                  sum_in = '0;
               end
            end
         end
         StExpRd: state_in = StExpMul;
         StExpMul: state_in = StExpWr;
         StExpWr: begin
            sum_in = sum_ff + SumWidth'(e_val);
            if (last_ptr) state_in = StDiv;
            else begin
               ptr_in = ptr_ff + IdxWidth'(1);
               state_in = StExpRd;
            end
         end
         StDiv: begin
            if (div_done) begin
               ptr_in = '0;
               state_in = StNrmRd;
            end
         end
         StNrmRd: state_in = StNrmMul;
         StNrmMul: if (!rsp_valid_ff || rsp_tready) state_in = StOut;
         StOut: begin
            if (last_ptr) begin
               state_in = StLoad;
               max_in = 16'sh8000;
               count_in = '0;
               sum_in = '0;
            end else begin
               ptr_in = ptr_ff + IdxWidth'(1);
               state_in = StNrmRd;
            end
         end
         default: state_in = StLoad;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StLoad;
         chan_ff <= 7'd64;
         max_ff <= 16'sh8000;
         count_ff <= '0;
         ptr_ff <= '0;
         sum_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         max_ff <= max_in;
         count_ff <= count_in;
         ptr_ff <= ptr_in;
         sum_ff <= sum_in;
         if (csr_valid) chan_ff <= csr_data[6:0];
         if (state_ff == StOut) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
      if (accept) score_mem[wr_idx] <= req_tdata;
      score_rd_ff <= score_mem[ptr_ff];
      exp_rd_ff <= exp_mem[ptr_ff];
      prod_ff <= 34'(diff[15:0] * 33'(Log2eQ16));
      if (state_ff == StExpWr) exp_mem[ptr_ff] <= e_val;
      if (div_done) recip_ff <= div_q;
      nprod_ff <= exp_rd_ff * recip_ff;
      if (state_ff == StOut) begin
         rsp_data_ff <= (rounded[49:16] > 34'd65535) ? 16'hFFFF : rounded[31:16];
         rsp_last_ff <= last_ptr;
      end
   end

`ifndef SYNTHESIS
   a_no_in_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != StLoad |-> !req_tready) else $error("ready while busy");
   a_sum_nz: assert property (@(posedge clock) disable iff (reset)
      div_start |-> sum_in != '0) else $error("zero sum");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      state_ff == StOut |=> rsp_valid_ff) else $error("result lost");
`endif
endmodule
`default_nettype wire
